>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks on the rising clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Types, constants and constant tables of the stereo peak compressor.
// ----------------------------------------------------------------------------
package spc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COEFF_BITS  = 16;
   localparam int LOG_FRAC    = 16;
   localparam int MUL_W       = 32;
   localparam logic [16:0] UNITY     = 17'd65536;
   // 0.0001 in Q1.23, rounded
   localparam logic [23:0] ENV_FLOOR = 24'd839;

   // Register indexes
   localparam logic [2:0] CSR_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_ATTACK    = 3'd1;
   localparam logic [2:0] CSR_RELEASE   = 3'd2;
   localparam logic [2:0] CSR_INV_RATIO = 3'd3;
   localparam logic [2:0] CSR_STEREO    = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENV_A,
      ST_ENV_B,
      ST_ENV_C,
      ST_CHECK,
      ST_LOG_INIT,
      ST_LOG_MUL,
      ST_LOG_UPD,
      ST_EXP_Q,
      ST_EXP_SPLIT,
      ST_EXP_MUL,
      ST_EXP_UPD,
      ST_GAIN,
      ST_APPLY_L,
      ST_APPLY_R,
      ST_DONE
   } state_type;

   typedef logic [30:0] root_tab_type [LOG_FRAC];

   // Truncated integer square root, two bits per round
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = v;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Q30 factors 2^(2^-(k+1)) for entry k, each the root of the one before
   function automatic root_tab_type build_root_tab();
      root_tab_type t;
      logic [63:0]  v;
      v = isqrt64(64'd1 << 61);
      t[0] = v[30:0];
      for (int i = 1; i < LOG_FRAC; i++) begin
         v = isqrt64({33'd0, t[i-1]} << 30);
         t[i] = v[30:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOT_TAB = build_root_tab();

   // Position of the highest set bit
   function automatic logic [4:0] msb_pos(input logic [23:0] x);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 24; i++) begin
         if (x[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

>>> rtl/spc_mul.sv
// ----------------------------------------------------------------------------
// spc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module spc_mul (
   input  logic                          clock,
   input  logic [spc_pkg::MUL_W-1:0]     mul_a,
   input  logic [spc_pkg::MUL_W-1:0]     mul_b,
   output logic [2*spc_pkg::MUL_W-1:0]   prod_ff
);

   logic [2*spc_pkg::MUL_W-1:0] prod_in;

   // Multiply
   assign prod_in = {{spc_pkg::MUL_W{1'b0}}, mul_a} * {{spc_pkg::MUL_W{1'b0}}, mul_b};

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/stereo_peak_compressor.sv
// ----------------------------------------------------------------------------
// stereo_peak_compressor
// Feed-forward peak compressor; one multiplier shared under a sequencer.
// A request is taken only while idle; the envelope is then updated and, while
// compressing, log2 and exp2 run bit-serially on the shared multiplier.
// The next frame waits for the last result to load; a stalled sink delays that.
// Reset: synchronous; control registers take defaults, envelope clears to zero.
// ----------------------------------------------------------------------------
module stereo_peak_compressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // left_sample[23:0], right_sample[47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // left_out[23:0], right_out[47:24],
                                    // gain_applied[64:48], zero pad above
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [22:0] csr_wdata
);

   spc_pkg::state_type state_ff, state_in;

   logic [22:0] thr_ff;
   logic [15:0] atk_ff, rel_ff;
   logic [16:0] ir_ff;
   logic        stereo_ff;

   logic [23:0] left_ff, left_in, right_ff, right_in;
   logic [23:0] env_ff, env_in;
   logic [40:0] acc_ff, acc_in;
   logic [30:0] m_ff, m_in;
   logic [15:0] frac_ff, frac_in;
   logic [4:0]  msb_ff, msb_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        sel_ff, sel_in;
   logic [20:0] log_env_ff, log_env_in;
   logic [20:0] d_ff, d_in;
   logic [15:0] g_ff, g_in;
   logic [6:0]  s_ff, s_in;
   logic [16:0] gain_ff, gain_in;
   logic [23:0] lout_ff, lout_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [71:0] rsp_tdata_ff, rsp_tdata_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic        rsp_load;

   logic [23:0] al, ar, level, log_x;
   logic [15:0] coef;
   logic [16:0] coef_c, ir_sat;
   logic [41:0] env_sum;
   logic        above;
   logic [4:0]  log_msb;
   logic [31:0] sq;
   logic [15:0] frac_new;
   logic [20:0] log_v;
   logic [38:0] q_sum;
   logic [22:0] q;
   logic [31:0] rnd;
   logic [23:0] rout;

   // Round a gained magnitude and restore its sign
   function automatic logic [23:0] gained(input logic [63:0] p, input logic neg);
      logic [41:0] r;
      r = {1'b0, p[40:0]} + 42'd32768;
      return neg ? (24'd0 - r[39:16]) : r[39:16];
   endfunction

   spc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   // Detector level and smoothing coefficient
   assign al     = left_ff[23] ? (24'd0 - left_ff) : left_ff;
   assign ar     = right_ff[23] ? (24'd0 - right_ff) : right_ff;
   assign level  = (stereo_ff && ar > al) ? ar : al;
   assign coef   = (level > env_ff) ? atk_ff : rel_ff;
   assign coef_c = spc_pkg::UNITY - {1'b0, coef};
   assign ir_sat = (ir_ff > spc_pkg::UNITY) ? spc_pkg::UNITY : ir_ff;
   assign env_sum = {1'b0, acc_ff} + {1'b0, prod[40:0]} + 42'd32768;
   assign above  = (env_ff > {1'b0, thr_ff}) && (env_ff > spc_pkg::ENV_FLOOR);

   // Log operand and normalization
   always_comb begin
      log_x = sel_ff ? {1'b0, thr_ff} : env_ff;
      if (log_x == 24'd0) log_x = 24'd1;
   end
   assign log_msb  = spc_pkg::msb_pos(log_x);
   assign sq       = prod[61:30];
   assign frac_new = {frac_ff[14:0], sq[31]};
   assign log_v    = {msb_ff, frac_new};

   // Exponent split and gain rounding
   assign q_sum = prod[38:0] + 39'd32768;
   assign q     = q_sum[38:16];
   assign rnd   = {1'b0, m_ff} + (32'd1 << (s_ff[4:0] - 5'd1));
   assign rout  = stereo_ff ? gained(prod, right_ff[23]) : 24'd0;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spc_pkg::ST_IDLE:      if (req_tvalid) state_in = spc_pkg::ST_ENV_A;
         spc_pkg::ST_ENV_A:     state_in = spc_pkg::ST_ENV_B;
         spc_pkg::ST_ENV_B:     state_in = spc_pkg::ST_ENV_C;
         spc_pkg::ST_ENV_C:     state_in = spc_pkg::ST_CHECK;
         spc_pkg::ST_CHECK:
            state_in = above ? spc_pkg::ST_LOG_INIT : spc_pkg::ST_APPLY_L;
         spc_pkg::ST_LOG_INIT:  state_in = spc_pkg::ST_LOG_MUL;
         spc_pkg::ST_LOG_MUL:   state_in = spc_pkg::ST_LOG_UPD;
         spc_pkg::ST_LOG_UPD: begin
            if (cnt_ff != 4'd15) state_in = spc_pkg::ST_LOG_MUL;
            else if (!sel_ff)    state_in = spc_pkg::ST_LOG_INIT;
            else                 state_in = spc_pkg::ST_EXP_Q;
         end
         spc_pkg::ST_EXP_Q:     state_in = spc_pkg::ST_EXP_SPLIT;
         spc_pkg::ST_EXP_SPLIT:
            state_in = (q[15:0] == 16'd0) ? spc_pkg::ST_GAIN : spc_pkg::ST_EXP_MUL;
         spc_pkg::ST_EXP_MUL:   state_in = spc_pkg::ST_EXP_UPD;
         spc_pkg::ST_EXP_UPD:
            state_in = (cnt_ff == 4'd15) ? spc_pkg::ST_GAIN : spc_pkg::ST_EXP_MUL;
         spc_pkg::ST_GAIN:      state_in = spc_pkg::ST_APPLY_L;
         spc_pkg::ST_APPLY_L:   state_in = spc_pkg::ST_APPLY_R;
         spc_pkg::ST_APPLY_R:   state_in = spc_pkg::ST_DONE;
         spc_pkg::ST_DONE:      if (rsp_load) state_in = spc_pkg::ST_IDLE;
         default:               state_in = spc_pkg::ST_IDLE;
      endcase
   end

   // Handshake and multiplier operands
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         spc_pkg::ST_IDLE:    req_tready = 1'b1;
         spc_pkg::ST_ENV_A: begin
            mul_a = {8'd0, env_ff};
            mul_b = {16'd0, coef};
         end
         spc_pkg::ST_ENV_B: begin
            mul_a = {8'd0, level};
            mul_b = {15'd0, coef_c};
         end
         spc_pkg::ST_LOG_MUL: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         spc_pkg::ST_EXP_Q: begin
            mul_a = {11'd0, d_ff};
            mul_b = {15'd0, spc_pkg::UNITY - ir_sat};
         end
         spc_pkg::ST_EXP_MUL: begin
            mul_a = {1'b0, m_ff};
            mul_b = g_ff[15] ? {1'b0, spc_pkg::ROOT_TAB[cnt_ff]} : (32'd1 << 30);
         end
         spc_pkg::ST_APPLY_L: begin
            mul_a = {8'd0, al};
            mul_b = {15'd0, gain_ff};
         end
         spc_pkg::ST_APPLY_R: begin
            mul_a = {8'd0, ar};
            mul_b = {15'd0, gain_ff};
         end
         spc_pkg::ST_DONE: begin
            // hold the right product until the result register frees
            mul_a    = {8'd0, ar};
            mul_b    = {15'd0, gain_ff};
            rsp_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      left_in    = left_ff;
      right_in   = right_ff;
      env_in     = env_ff;
      acc_in     = acc_ff;
      m_in       = m_ff;
      frac_in    = frac_ff;
      msb_in     = msb_ff;
      cnt_in     = cnt_ff;
      sel_in     = sel_ff;
      log_env_in = log_env_ff;
      d_in       = d_ff;
      g_in       = g_ff;
      s_in       = s_ff;
      gain_in    = gain_ff;
      lout_in    = lout_ff;
      case (state_ff)
         spc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               left_in  = req_tdata[23:0];
               right_in = req_tdata[47:24];
            end
         end
         spc_pkg::ST_ENV_B:  acc_in = prod[40:0];
         spc_pkg::ST_ENV_C:  env_in = env_sum[39:16];
         spc_pkg::ST_CHECK: begin
            sel_in  = 1'b0;
            gain_in = spc_pkg::UNITY;
         end
         spc_pkg::ST_LOG_INIT: begin
            msb_in  = log_msb;
            m_in    = 31'(log_x) << (5'd30 - log_msb);
            frac_in = '0;
            cnt_in  = '0;
         end
         spc_pkg::ST_LOG_UPD: begin
            frac_in = frac_new;
            m_in    = sq[31] ? sq[31:1] : sq[30:0];
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               if (!sel_ff) begin
                  log_env_in = log_v;
                  sel_in     = 1'b1;
               end else begin
                  d_in = log_env_ff - log_v;
               end
            end
         end
         spc_pkg::ST_EXP_SPLIT: begin
            m_in   = 31'd1 << 30;
            cnt_in = '0;
            g_in   = 16'd0 - q[15:0];
            s_in   = (q[15:0] == 16'd0) ? (q[22:16] + 7'd14) : (q[22:16] + 7'd15);
         end
         spc_pkg::ST_EXP_UPD: begin
            m_in   = prod[60:30];
            g_in   = {g_ff[14:0], 1'b0};
            cnt_in = cnt_ff + 4'd1;
         end
         spc_pkg::ST_GAIN: begin
            // shifts of 32 or more leave less than one LSB
            gain_in = (s_ff >= 7'd32) ? 17'd0 : 17'(rnd >> s_ff[4:0]);
         end
         spc_pkg::ST_APPLY_R: lout_in = gained(prod, left_ff[23]);
         default: begin
            lout_in = lout_ff;
         end
      endcase
   end

   // Result register
   assign rsp_tvalid_in = rsp_load || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_tdata_in  = rsp_load ? {7'd0, gain_ff, rout, lout_ff} : rsp_tdata_ff;
   assign rsp_tvalid    = rsp_tvalid_ff;
   assign rsp_tdata     = rsp_tdata_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spc_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         env_ff        <= '0;
         thr_ff        <= 23'h7FFFFF;
         atk_ff        <= '0;
         rel_ff        <= '0;
         ir_ff         <= spc_pkg::UNITY;
         stereo_ff     <= 1'b1;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         env_ff        <= env_in;
         if (csr_we) begin
            case (csr_index)
               spc_pkg::CSR_THRESHOLD: thr_ff    <= csr_wdata;
               spc_pkg::CSR_ATTACK:    atk_ff    <= csr_wdata[15:0];
               spc_pkg::CSR_RELEASE:   rel_ff    <= csr_wdata[15:0];
               spc_pkg::CSR_INV_RATIO: ir_ff     <= csr_wdata[16:0];
               spc_pkg::CSR_STEREO:    stereo_ff <= csr_wdata[0];
               default:                stereo_ff <= stereo_ff;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      acc_ff       <= acc_in;
      m_ff         <= m_in;
      frac_ff      <= frac_in;
      msb_ff       <= msb_in;
      cnt_ff       <= cnt_in;
      sel_ff       <= sel_in;
      log_env_ff   <= log_env_in;
      d_ff         <= d_in;
      g_ff         <= g_in;
      s_ff         <= s_in;
      gain_ff      <= gain_in;
      lout_ff      <= lout_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

`include "assert_macros.svh"

   `ASSERT_IMPL(a_ready_idle, clock, reset, req_tready, state_ff == spc_pkg::ST_IDLE)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready,
                state_ff == spc_pkg::ST_ENV_A)
   `ASSERT_IMPL(a_gain_max, clock, reset, rsp_tvalid, rsp_tdata[64:48] <= spc_pkg::UNITY)
   `ASSERT_NEXT(a_mono_right, clock, reset, rsp_load && !stereo_ff,
                rsp_tdata[47:24] == 24'd0)

endmodule
